>>> src/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Types, widths and helpers shared by the cubic Bezier bounding box core.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int COORD_W = 32;
  localparam int T_W     = 16;
  localparam int A_W     = 38;
  localparam int C_W     = 36;
  localparam int MAG_W   = 36;
  localparam int HALF_W  = 18;
  localparam int PP_W    = HALF_W + MAG_W;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int DISC_W  = 75;
  localparam int SQ_W    = 74;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int NUM_W   = 40;
  localparam int DEN_W   = 39;
  localparam int DM_W    = 39;
  localparam int LP_W    = COORD_W + T_W + 2;
  localparam int NROOT   = 6;

  localparam int ZT_W    = 16;
  localparam int DT_W    = 33;
  localparam int TM_W    = 15;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 64;

  localparam logic [ZT_W-1:0] ZT_RST = ZT_W'(0);
  localparam logic [DT_W-1:0] DT_RST = DT_W'(429497);
  localparam logic [TM_W-1:0] TM_RST = TM_W'(7);

  localparam int HALF_T = 1 << (T_W - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_ZERO_TOL = 2'd0,
    REG_DISC_THR = 2'd1,
    REG_T_MARGIN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ZT_W-1:0] zero_tol;
    logic [DT_W-1:0] disc_thr;
    logic [TM_W-1:0] t_margin;
  } cfg_t;

  typedef struct packed {
    logic              live;
    logic              skip;
    coord_t [3:0]      p;
  } scarry_t;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [A_W-1:0] b;
    logic signed [C_W-1:0] c;
    logic                  qv;
    logic                  lv;
  } coef_t;

  typedef struct packed {
    logic                        live;
    logic [NROOT-1:0]            hit;
    logic [NROOT-1:0][T_W-1:0]   t;
    coord_t [3:0][2:0]           pts;
  } ecarry_t;

  function automatic logic signed [LP_W-1:0] lerp_mul(coord_t a, coord_t b,
                                                      logic [T_W-1:0] t);
    logic signed [COORD_W:0] d;
    logic signed [T_W:0]     ts;
    d  = (COORD_W+1)'(b) - (COORD_W+1)'(a);
    ts = {1'b0, t};
    return d * ts;
  endfunction

  function automatic coord_t lerp_fin(coord_t a, logic signed [LP_W-1:0] prod);
    logic signed [LP_W-1:0] r;
    r = (prod + LP_W'(HALF_T)) >>> T_W;
    return a + r[COORD_W-1:0];
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> src/cubic_bezier_bounds_core.sv
// ----------------------------------------------------------------------------
// cubic_bezier_bounds_core
// Axis-aligned bounding box of a 3D cubic Bezier curve in signed Q16.16.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   p0_x_i .. p3_z_i
//   out      output     out_valid_o / out_stall_i min_x_o .. max_z_o
//   cfg      input      APB write/read            zero_tolerance, disc_threshold,
//                                                 t_margin at 8*i
//
// One curve per cycle while the output is not stalled; each axis solver holds
// the 37-stage square root and the 16-stage divider.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_stall_o follows it.
// ----------------------------------------------------------------------------
module cubic_bezier_bounds_core import cbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  coord_t            p0_x_i,
  input  coord_t            p0_y_i,
  input  coord_t            p0_z_i,
  input  coord_t            p1_x_i,
  input  coord_t            p1_y_i,
  input  coord_t            p1_z_i,
  input  coord_t            p2_x_i,
  input  coord_t            p2_y_i,
  input  coord_t            p2_z_i,
  input  coord_t            p3_x_i,
  input  coord_t            p3_y_i,
  input  coord_t            p3_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output coord_t            min_x_o,
  output coord_t            min_y_o,
  output coord_t            min_z_o,
  output coord_t            max_x_o,
  output coord_t            max_y_o,
  output coord_t            max_z_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration
  cfg_t cfg_q;
  reg_idx_e ridx;
  assign ridx   = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign pready = 1'b1;

  always_comb begin
    unique case (ridx)
      REG_ZERO_TOL: prdata = DATA_W'(cfg_q.zero_tol);
      REG_DISC_THR: prdata = DATA_W'(cfg_q.disc_thr);
      REG_T_MARGIN: prdata = DATA_W'(cfg_q.t_margin);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_tol <= ZT_RST;
      cfg_q.disc_thr <= DT_RST;
      cfg_q.t_margin <= TM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ZERO_TOL: cfg_q.zero_tol <= pwdata[ZT_W-1:0];
        REG_DISC_THR: cfg_q.disc_thr <= pwdata[DT_W-1:0];
        REG_T_MARGIN: cfg_q.t_margin <= pwdata[TM_W-1:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // input register
  logic              live0_q;
  coord_t [3:0][2:0] pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live0_q <= 1'b0;
    end else if (en) begin
      live0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pin_q[0] <= {p0_z_i, p0_y_i, p0_x_i};
      pin_q[1] <= {p1_z_i, p1_y_i, p1_x_i};
      pin_q[2] <= {p2_z_i, p2_y_i, p2_x_i};
      pin_q[3] <= {p3_z_i, p3_y_i, p3_x_i};
    end
  end

  logic [2:0]   in_box;
  coord_t [3:0] pax [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 4; m++) begin
        pax[k][m] = pin_q[m][k];
      end
      in_box[k] = ((pin_q[1][k] >= pin_q[0][k] && pin_q[1][k] <= pin_q[3][k]) ||
                   (pin_q[1][k] >= pin_q[3][k] && pin_q[1][k] <= pin_q[0][k])) &&
                  ((pin_q[2][k] >= pin_q[0][k] && pin_q[2][k] <= pin_q[3][k]) ||
                   (pin_q[2][k] >= pin_q[3][k] && pin_q[2][k] <= pin_q[0][k]));
    end
  end

  // axis solvers
  logic [2:0]              slive;
  coord_t [3:0]            spts [3];
  logic [1:0]              shit [3];
  logic [1:0][T_W-1:0]     st   [3];

  for (genvar k = 0; k < 3; k++) begin : g_ax
    cbb_solver u_solver (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .live_i (live0_q),
      .skip_i (&in_box),
      .p_i    (pax[k]),
      .cfg_i  (cfg_q),
      .live_o (slive[k]),
      .p_o    (spts[k]),
      .hit_o  (shit[k]),
      .t_o    (st[k])
    );
  end

  ecarry_t c0;
  always_comb begin
    c0.live = &slive;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 4; m++) begin
        c0.pts[m][k] = spts[k][m];
      end
      for (int i = 0; i < 2; i++) begin
        c0.hit[2*k+i] = shit[k][i];
        c0.t[2*k+i]   = st[k][i];
      end
    end
  end

  // de Casteljau evaluation, product and sum in separate stages
  ecarry_t car_q [6];
  logic signed [LP_W-1:0] l1p_q [NROOT][3][3];
  coord_t                 l1_q  [NROOT][3][3];
  logic signed [LP_W-1:0] l2p_q [NROOT][3][2];
  coord_t                 l2a_q [NROOT][3][2];
  coord_t                 l2_q  [NROOT][3][2];
  logic signed [LP_W-1:0] l3p_q [NROOT][3];
  coord_t                 l3a_q [NROOT][3];
  coord_t                 l3_q  [NROOT][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 6; e++) begin
        car_q[e] <= '0;
      end
    end else if (en) begin
      car_q[0] <= c0;
      for (int e = 1; e < 6; e++) begin
        car_q[e] <= car_q[e-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NROOT; j++) begin
        for (int k = 0; k < 3; k++) begin
          for (int m = 0; m < 3; m++) begin
            l1p_q[j][k][m] <= lerp_mul(c0.pts[m][k], c0.pts[m+1][k], c0.t[j]);
            l1_q[j][k][m]  <= lerp_fin(car_q[0].pts[m][k], l1p_q[j][k][m]);
          end
          for (int m = 0; m < 2; m++) begin
            l2p_q[j][k][m] <= lerp_mul(l1_q[j][k][m], l1_q[j][k][m+1], car_q[1].t[j]);
            l2a_q[j][k][m] <= l1_q[j][k][m];
            l2_q[j][k][m]  <= lerp_fin(l2a_q[j][k][m], l2p_q[j][k][m]);
          end
          l3p_q[j][k] <= lerp_mul(l2_q[j][k][0], l2_q[j][k][1], car_q[3].t[j]);
          l3a_q[j][k] <= l2_q[j][k][0];
          l3_q[j][k]  <= lerp_fin(l3a_q[j][k], l3p_q[j][k]);
        end
      end
    end
  end

  // min/max tree
  coord_t cand [3][8];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cand[k][0] = car_q[5].pts[0][k];
      cand[k][1] = car_q[5].pts[3][k];
      for (int j = 0; j < NROOT; j++) begin
        cand[k][2+j] = car_q[5].hit[j] ? l3_q[j][k] : car_q[5].pts[0][k];
      end
    end
  end

  logic [2:0] rlive_q;
  coord_t     mn1_q [3][4];
  coord_t     mx1_q [3][4];
  coord_t     mn2_q [3][2];
  coord_t     mx2_q [3][2];
  coord_t     mn3_q [3];
  coord_t     mx3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlive_q <= '0;
    end else if (en) begin
      rlive_q <= {rlive_q[1:0], car_q[5].live};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 4; i++) begin
          mn1_q[k][i] <= cmin(cand[k][2*i], cand[k][2*i+1]);
          mx1_q[k][i] <= cmax(cand[k][2*i], cand[k][2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
          mn2_q[k][i] <= cmin(mn1_q[k][2*i], mn1_q[k][2*i+1]);
          mx2_q[k][i] <= cmax(mx1_q[k][2*i], mx1_q[k][2*i+1]);
        end
        mn3_q[k] <= cmin(mn2_q[k][0], mn2_q[k][1]);
        mx3_q[k] <= cmax(mx2_q[k][0], mx2_q[k][1]);
      end
    end
  end

  assign out_valid_o = rlive_q[2];
  assign min_x_o     = mn3_q[0];
  assign min_y_o     = mn3_q[1];
  assign min_z_o     = mn3_q[2];
  assign max_x_o     = mx3_q[0];
  assign max_y_o     = mx3_q[1];
  assign max_z_o     = mx3_q[2];

endmodule

>>> src/cbb_solver.sv
// ----------------------------------------------------------------------------
// cbb_solver
// One axis: derivative coefficients, discriminant, square root and the
// division of each root into Q0.16 t, all as a stallable pipeline.
// ----------------------------------------------------------------------------
module cbb_solver import cbb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      live_i,
  input  logic                      skip_i,
  input  coord_t [3:0]              p_i,
  input  cfg_t                      cfg_i,
  output logic                      live_o,
  output coord_t [3:0]              p_o,
  output logic [1:0]                hit_o,
  output logic [1:0][T_W-1:0]       t_o
);

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    coef_t             co;
    scarry_t           cr;
  } sq_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [DEN_W-1:0] den;
    logic [1:0]              v;
    scarry_t                 cr;
  } num_t;

  typedef struct packed {
    logic [DM_W-1:0] r0;
    logic [DM_W-1:0] r1;
    logic [DM_W-1:0] ud;
    logic [T_W-1:0]  q0;
    logic [T_W-1:0]  q1;
    logic [1:0]      ok;
    scarry_t         cr;
  } dv_t;

  function automatic logic [MAG_W-1:0] mag_a(logic signed [A_W-1:0] v);
    return MAG_W'(v[A_W-1] ? -v : v);
  endfunction

  function automatic logic [DM_W-1:0] mag_n(logic signed [NUM_W-1:0] v);
    return DM_W'(v[NUM_W-1] ? -v : v);
  endfunction

  // stage 1: coefficients
  scarry_t cr1_q, cr2_q, cr3_q, cr4_q, cr5_q;
  coef_t   co1_q, co2_q, co3_q, co4_q, co5_q;
  coef_t   co1_d;

  always_comb begin
    logic signed [A_W-1:0] e0, e1, e2, e3, cc;
    e0 = A_W'(p_i[0]);
    e1 = A_W'(p_i[1]);
    e2 = A_W'(p_i[2]);
    e3 = A_W'(p_i[3]);
    cc = 3 * (e1 - e0);
    co1_d.a  = A_W'(3 * (e3 - e0) + 9 * (e1 - e2));
    co1_d.b  = A_W'(6 * (e0 + e2) - 12 * e1);
    co1_d.c  = C_W'(cc);
    co1_d.qv = 1'b0;
    co1_d.lv = 1'b0;
  end

  // stage 2: magnitudes, small flags
  logic [MAG_W-1:0] ma2_q, mb2_q, mc2_q;
  logic             neg2_q, neg3_q, neg4_q;
  logic             asm2_q, asm3_q, asm4_q, asm5_q;
  logic             bsm2_q, bsm3_q, bsm4_q, bsm5_q;

  // stage 3: partial products
  logic [PP_W-1:0]  bbl3_q, bbh3_q, acl3_q, ach3_q;
  // stage 4: products
  logic [PROD_W-1:0] bb4_q, ac4_q;
  // stage 5: discriminant
  logic [DISC_W-1:0] disc5_q;

  logic [DISC_W-1:0] bbx, acx, disc_d;
  always_comb begin
    bbx    = DISC_W'(bb4_q);
    acx    = DISC_W'({ac4_q, 2'b00});
    disc_d = neg4_q ? bbx + acx : bbx - acx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr1_q <= '0; cr2_q <= '0; cr3_q <= '0; cr4_q <= '0; cr5_q <= '0;
    end else if (en_i) begin
      cr1_q <= '{live: live_i, skip: skip_i, p: p_i};
      cr2_q <= cr1_q;
      cr3_q <= cr2_q;
      cr4_q <= cr3_q;
      cr5_q <= cr4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      co1_q  <= co1_d;
      co2_q  <= co1_q;
      ma2_q  <= mag_a(co1_q.a);
      mb2_q  <= mag_a(co1_q.b);
      mc2_q  <= mag_a(A_W'(co1_q.c));
      neg2_q <= co1_q.a[A_W-1] ^ co1_q.c[C_W-1];
      asm2_q <= mag_a(co1_q.a) <= MAG_W'(cfg_i.zero_tol);
      bsm2_q <= mag_a(co1_q.b) <= MAG_W'(cfg_i.zero_tol);
      co3_q  <= co2_q;
      bbl3_q <= mb2_q[HALF_W-1:0] * mb2_q;
      bbh3_q <= mb2_q[MAG_W-1:HALF_W] * mb2_q;
      acl3_q <= ma2_q[HALF_W-1:0] * mc2_q;
      ach3_q <= ma2_q[MAG_W-1:HALF_W] * mc2_q;
      neg3_q <= neg2_q;
      asm3_q <= asm2_q;
      bsm3_q <= bsm2_q;
      co4_q  <= co3_q;
      bb4_q  <= (PROD_W'(bbh3_q) << HALF_W) + PROD_W'(bbl3_q);
      ac4_q  <= (PROD_W'(ach3_q) << HALF_W) + PROD_W'(acl3_q);
      neg4_q <= neg3_q;
      asm4_q <= asm3_q;
      bsm4_q <= bsm3_q;
      co5_q  <= co4_q;
      disc5_q <= disc_d;
      asm5_q <= asm4_q;
      bsm5_q <= bsm4_q;
    end
  end

  // stage 6 and square root, one result bit per stage
  sq_t sq_q [ROOT_W+1];
  sq_t sq0_d;

  always_comb begin
    sq0_d      = '0;
    sq0_d.rem  = disc5_q[SQ_W-1:0];
    sq0_d.co   = co5_q;
    sq0_d.cr   = cr5_q;
    sq0_d.co.qv = !asm5_q && !disc5_q[DISC_W-1] &&
                  (disc5_q[SQ_W-1:0] > SQ_W'(cfg_i.disc_thr));
    sq0_d.co.lv = asm5_q && !bsm5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (en_i) begin
      sq_q[0] <= sq0_d;
    end
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sq
    localparam int BI = ROOT_W - 1 - g;
    logic [SQ_W+1:0] trial, remx;
    sq_t             nxt;
    always_comb begin
      trial = ((SQ_W+2)'(sq_q[g].root) << (BI + 1)) + ((SQ_W+2)'(1) << (2 * BI));
      remx  = (SQ_W+2)'(sq_q[g].rem);
      nxt   = sq_q[g];
      if (remx >= trial) begin
        nxt.rem  = SQ_W'(remx - trial);
        nxt.root = sq_q[g].root | (ROOT_W'(1) << BI);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[g+1] <= '0;
      end else if (en_i) begin
        sq_q[g+1] <= nxt;
      end
    end
  end

  // numerators and denominator
  num_t num_q, num_d;
  always_comb begin
    logic signed [NUM_W-1:0] bx, sx, cx;
    coef_t co;
    co = sq_q[ROOT_W].co;
    bx = NUM_W'(co.b);
    cx = NUM_W'(co.c);
    sx = NUM_W'(sq_q[ROOT_W].root);
    num_d.n0  = co.qv ? sx - bx : -cx;
    num_d.n1  = -bx - sx;
    num_d.den = co.qv ? DEN_W'({co.a, 1'b0}) : DEN_W'(co.b);
    num_d.v   = {co.qv, co.qv | co.lv};
    num_d.cr  = sq_q[ROOT_W].cr;
  end

  // root checks and divider
  dv_t dv_q [T_W+1];
  dv_t dv0_d;
  always_comb begin
    logic [DM_W-1:0] un0, un1, ud;
    logic            dz;
    un0 = mag_n(num_q.n0);
    un1 = mag_n(num_q.n1);
    ud  = mag_n(NUM_W'(num_q.den));
    dz  = num_q.den == '0;
    dv0_d.r0 = un0;
    dv0_d.r1 = un1;
    dv0_d.ud = ud;
    dv0_d.q0 = '0;
    dv0_d.q1 = '0;
    dv0_d.ok[0] = num_q.v[0] && num_q.n0 != '0 && !dz &&
                  (num_q.n0[NUM_W-1] == num_q.den[DEN_W-1]) && (un0 < ud);
    dv0_d.ok[1] = num_q.v[1] && num_q.n1 != '0 && !dz &&
                  (num_q.n1[NUM_W-1] == num_q.den[DEN_W-1]) && (un1 < ud);
    dv0_d.cr = num_q.cr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      dv_q[0] <= '0;
    end else if (en_i) begin
      num_q   <= num_d;
      dv_q[0] <= dv0_d;
    end
  end

  for (genvar g = 0; g < T_W; g++) begin : g_dv
    logic [DM_W:0] s0, s1, udx;
    logic          ge0, ge1;
    dv_t           nxt;
    always_comb begin
      udx = {1'b0, dv_q[g].ud};
      s0  = {dv_q[g].r0, 1'b0};
      s1  = {dv_q[g].r1, 1'b0};
      ge0 = s0 >= udx;
      ge1 = s1 >= udx;
      nxt = dv_q[g];
      nxt.r0 = ge0 ? DM_W'(s0 - udx) : DM_W'(s0);
      nxt.r1 = ge1 ? DM_W'(s1 - udx) : DM_W'(s1);
      nxt.q0 = {dv_q[g].q0[T_W-2:0], ge0};
      nxt.q1 = {dv_q[g].q1[T_W-2:0], ge1};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[g+1] <= '0;
      end else if (en_i) begin
        dv_q[g+1] <= nxt;
      end
    end
  end

  // margin window
  logic [1:0] hit_d;
  always_comb begin
    logic [T_W:0] s0, s1;
    s0 = (T_W+1)'(dv_q[T_W].q0) + (T_W+1)'(cfg_i.t_margin);
    s1 = (T_W+1)'(dv_q[T_W].q1) + (T_W+1)'(cfg_i.t_margin);
    hit_d[0] = dv_q[T_W].ok[0] && !dv_q[T_W].cr.skip && !s0[T_W] &&
               (dv_q[T_W].q0 > T_W'(cfg_i.t_margin));
    hit_d[1] = dv_q[T_W].ok[1] && !dv_q[T_W].cr.skip && !s1[T_W] &&
               (dv_q[T_W].q1 > T_W'(cfg_i.t_margin));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_o <= 1'b0;
      hit_o  <= '0;
    end else if (en_i) begin
      live_o <= dv_q[T_W].cr.live;
      hit_o  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o    <= dv_q[T_W].cr.p;
      t_o[0] <= dv_q[T_W].q0;
      t_o[1] <= dv_q[T_W].q1;
    end
  end

endmodule

>>> src/cbb_checker.sv
// ----------------------------------------------------------------------------
// cbb_checker
// Port-level checks on the bounding box core, bound to the top level.
// ----------------------------------------------------------------------------
module cbb_checker import cbb_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_stall_o,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input coord_t min_x_o,
  input coord_t min_y_o,
  input coord_t min_z_o,
  input coord_t max_x_o,
  input coord_t max_y_o,
  input coord_t max_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_x_o) &&
    $stable(min_y_o) && $stable(min_z_o) && $stable(max_x_o) &&
    $stable(max_y_o) && $stable(max_z_o))
    else $error("stalled box changed");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_x_o <= max_x_o) && (min_y_o <= max_y_o) &&
    (min_z_o <= max_z_o))
    else $error("box minimum above maximum");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held transfer");

endmodule

bind cubic_bezier_bounds_core cbb_checker u_cbb_checker (.*);
